// File: src/nps_pkg.sv
// Shared types and constants for the 3D nearest-point search core.
// No dependencies; imported by every module of the block.
package nps_pkg;

  localparam int unsigned COORD_W = 16;  // signed Q7.8 coordinate
  localparam int unsigned DIFF_W  = 17;  // coordinate difference
  localparam int unsigned SQ_W    = 34;  // signed product of two differences
  localparam int unsigned COST_W  = 36;  // sum of three squares, exact

  localparam int unsigned IDX_W   = 10;  // frame_index / best_index field
  localparam int unsigned FC_W    = 11;  // frame_count register

  // Stream word layouts.
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned M_TUSER_W = 1;

  // operation codes (s_axis_tuser)
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One store entry, x in the low bits.
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } frame_t;

  localparam int unsigned FRAME_W = $bits(frame_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } nps_state_e;

endpackage

// File: src/nearest_point_search_3d_core.sv
// Top level of the 3D nearest-point search core: stream ports, sequencer,
// best-so-far compare. Depends on nps_pkg, nps_frame_mem, nps_dist_pipe.
//
//  Channel   Dir  Word contents (low bit up)                       Notes
//  s_axis    in   tdata: frame_index[9:0] pos_x pos_y pos_z;        write or query
//                 tuser: operation (0 write, 1 query)
//  m_axis    out  tdata: best_index[9:0], zero pad; tuser: found     one per query
//  cfg       in   cfg_wdata_i: frame_count[10:0]                   write on cfg_we_i
//
// A write word is stored at its accept edge. A query word goes from accept to
// m_axis_tvalid through a scan of n = min(frame_count, MAX_FRAMES) entries:
// one RAM read per cycle, the three distance stages, the compare, the step
// into the done state and the output load; an empty query goes straight to done.
// Reset clears the sequencer, frame_count and the output valid; the store
// holds garbage until written, with no clearing pass. A result held by a
// stalled m_axis blocks only the next query's final load.
module nearest_point_search_3d_core #(
  parameter int unsigned MAX_FRAMES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // frame_index[9:0], pos_x, pos_y, pos_z
  input  logic [0:0]  s_axis_tuser,   // operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // best_index[9:0], zero pad
  output logic [0:0]  m_axis_tuser,   // found
  // configuration
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i     // frame_count
);
  import nps_pkg::*;

  // store address width, and a count width that holds MAX_FRAMES and frame_count
  localparam int unsigned AW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW0  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CNTW = (CW0 > FC_W) ? CW0 : FC_W;

  nps_state_e        state_q, state_d;
  logic [FC_W-1:0]   frame_count_q;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     last_q, last_d;
  frame_t            tgt_q;
  logic              rd_vld_q;
  logic [AW-1:0]     rd_idx_q;
  logic              best_vld_q, best_vld_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic [COST_W-1:0] best_cost_q, best_cost_d;
  logic              m_vld_q, m_vld_d;
  logic [IDX_W-1:0]  m_idx_q;
  logic              m_found_q;

  logic              s_acc;
  logic              op;
  logic [IDX_W-1:0]  in_idx;
  frame_t            in_frame;
  logic [CNTW-1:0]   n_clamp;
  logic [CNTW-1:0]   in_idx_ext;
  logic [CNTW-1:0]   best_idx_ext;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  frame_t            mem_rdata;

  logic              pipe_vld, pipe_busy;
  logic [AW-1:0]     pipe_idx;
  logic [COST_W-1:0] pipe_cost;
  logic              out_free;

  assign op       = s_axis_tuser[0];
  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_frame = s_axis_tdata[IDX_W +: FRAME_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign out_free      = !m_vld_q || m_axis_tready;

  // frame_count above the store depth searches the whole store
  assign n_clamp = (CNTW'(frame_count_q) > CNTW'(MAX_FRAMES)) ? CNTW'(MAX_FRAMES)
                                                             : CNTW'(frame_count_q);
  assign in_idx_ext   = CNTW'(in_idx);
  assign best_idx_ext = CNTW'(best_idx_q);

  // one port: writes only while idle, reads only while scanning
  assign mem_we   = s_acc && (op == OP_WRITE) && (in_idx_ext < CNTW'(MAX_FRAMES));
  assign mem_re   = (state_q == ST_SCAN);
  assign mem_addr = mem_re ? cnt_q : in_idx_ext[AW-1:0];

  nps_frame_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (in_frame),
    .rdata_o (mem_rdata)
  );

  nps_dist_pipe #(
    .AW (AW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (rd_vld_q),
    .idx_i   (rd_idx_q),
    .frame_i (mem_rdata),
    .tgt_i   (tgt_q),
    .vld_o   (pipe_vld),
    .idx_o   (pipe_idx),
    .cost_o  (pipe_cost),
    .busy_o  (pipe_busy)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_cost_d = best_cost_q;
    m_vld_d     = m_vld_q;

    if (m_vld_q && m_axis_tready) begin
      m_vld_d = 1'b0;
    end

    // strict less-than keeps the lowest index on ties
    if (pipe_vld && (!best_vld_q || (pipe_cost < best_cost_q))) begin
      best_vld_d  = 1'b1;
      best_idx_d  = pipe_idx;
      best_cost_d = pipe_cost;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_acc && (op == OP_QUERY)) begin
          best_vld_d = 1'b0;
          best_idx_d = '0;
          cnt_d      = '0;
          last_d     = AW'(n_clamp - CNTW'(1));
          state_d    = (n_clamp == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !pipe_busy && !pipe_vld) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_vld_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frame_count_q <= '0;
      rd_vld_q      <= 1'b0;
      best_vld_q    <= 1'b0;
      m_vld_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= mem_re;
      best_vld_q <= best_vld_d;
      m_vld_q    <= m_vld_d;
      if (cfg_we_i) begin
        frame_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    last_q      <= last_d;
    rd_idx_q    <= cnt_q;
    best_idx_q  <= best_idx_d;
    best_cost_q <= best_cost_d;
    if (s_acc && (op == OP_QUERY)) begin
      tgt_q <= in_frame;
    end
    if ((state_q == ST_DONE) && out_free) begin
      m_idx_q   <= best_idx_ext[IDX_W-1:0];
      m_found_q <= best_vld_q;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {(M_TDATA_W - IDX_W)'(0), m_idx_q};
  assign m_axis_tuser  = m_found_q;

endmodule

// File: src/nps_frame_mem.sv
// Frame position store: single-port synchronous RAM with a registered read.
// Depends on nps_pkg for the entry type.
module nps_frame_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  nps_pkg::frame_t  wdata_i,
  output nps_pkg::frame_t  rdata_o
);
  import nps_pkg::*;

  frame_t mem_q [DEPTH];
  frame_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/nps_dist_pipe.sv
// Squared Euclidean distance pipeline: difference, square, sum stages.
// Depends on nps_pkg for widths and the entry type. Index tag rides along.
module nps_dist_pipe #(
  parameter int unsigned AW = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [AW-1:0]               idx_i,
  input  nps_pkg::frame_t             frame_i,
  input  nps_pkg::frame_t             tgt_i,
  output logic                        vld_o,
  output logic [AW-1:0]               idx_o,
  output logic [nps_pkg::COST_W-1:0]  cost_o,
  output logic                        busy_o
);
  import nps_pkg::*;

  logic                     diff_vld_q, sq_vld_q, cost_vld_q;
  logic [AW-1:0]            diff_idx_q, sq_idx_q, cost_idx_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic signed [SQ_W-1:0]   sx_q, sy_q, sz_q;
  logic [COST_W-1:0]        cost_q;

  logic signed [DIFF_W-1:0] dx_d, dy_d, dz_d;
  logic signed [SQ_W-1:0]   sx_d, sy_d, sz_d;
  logic [COST_W-1:0]        cost_d;

  always_comb begin
    dx_d = DIFF_W'(frame_i.x) - DIFF_W'(tgt_i.x);
    dy_d = DIFF_W'(frame_i.y) - DIFF_W'(tgt_i.y);
    dz_d = DIFF_W'(frame_i.z) - DIFF_W'(tgt_i.z);
    sx_d = SQ_W'(dx_q) * SQ_W'(dx_q);
    sy_d = SQ_W'(dy_q) * SQ_W'(dy_q);
    sz_d = SQ_W'(dz_q) * SQ_W'(dz_q);
    // squares are never negative
    cost_d = {2'b00, sx_q} + {2'b00, sy_q} + {2'b00, sz_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_vld_q <= 1'b0;
      sq_vld_q   <= 1'b0;
      cost_vld_q <= 1'b0;
    end else begin
      diff_vld_q <= vld_i;
      sq_vld_q   <= diff_vld_q;
      cost_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    dz_q       <= dz_d;
    diff_idx_q <= idx_i;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    sz_q       <= sz_d;
    sq_idx_q   <= diff_idx_q;
    cost_q     <= cost_d;
    cost_idx_q <= sq_idx_q;
  end

  assign vld_o  = cost_vld_q;
  assign idx_o  = cost_idx_q;
  assign cost_o = cost_q;
  assign busy_o = diff_vld_q | sq_vld_q | cost_vld_q;

endmodule

// File: dv/nearest_point_search_3d_core_tb.sv
// Self-checking testbench for nearest_point_search_3d_core: stream driver,
// result monitor and an in-bench nearest-frame predictor. Depends on nps_pkg and the core.
module nearest_point_search_3d_core_tb;
  import nps_pkg::*;

  localparam int unsigned MAX_FRAMES = 1024;
  localparam int unsigned IDLE_LIMIT = 4000;   // > full 1024-frame scan + long hold
  localparam int unsigned SETTLE_CYC = 16;     // quiet cycles before a cfg write
  localparam int unsigned LONG_HOLD  = 300;    // output back-pressure stretch
  localparam int unsigned RAND_WORDS = 500;
  localparam int unsigned TAIL_FILL  = 64;     // prefix the last part fills before searching

  typedef logic signed [COORD_W-1:0] coord_t;

  // One input word before packing.
  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    coord_t           x;
    coord_t           y;
    coord_t           z;
  } stim_word_t;

  // One expected result word.
  typedef struct packed {
    logic [IDX_W-1:0] best;
    logic             found;
  } nearest_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;     // frame_index[9:0], pos_x, pos_y, pos_z
  logic [0:0]        s_axis_tuser = '0;     // operation
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;          // best_index[9:0], zero pad
  logic [0:0]        m_axis_tuser;          // found
  logic              cfg_we_i = 1'b0;
  logic [FC_W-1:0]   cfg_wdata_i = '0;      // frame_count

  always #5 clk_i = ~clk_i;

  nearest_point_search_3d_core #(
    .MAX_FRAMES(MAX_FRAMES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow copy of the frame store and of frame_count.
  // frame_valid tracks which entries were written so a search never touches
  // an entry that still holds power-up garbage.
  // ---------------------------------------------------------------------------
  coord_t          frame_x [MAX_FRAMES];
  coord_t          frame_y [MAX_FRAMES];
  coord_t          frame_z [MAX_FRAMES];
  bit              frame_valid [MAX_FRAMES];
  logic [FC_W-1:0] fc_shadow = '0;

  stim_word_t pending_words[$];  // words waiting for the driver
  nearest_t   nearest_q[$];      // expected result words, oldest first

  int  err_count = 0;
  int  n_writes = 0;
  int  n_queries = 0;
  int  n_results = 0;
  int  n_settings = 0;
  bit  quiet = 1'b0;             // no idling on either side in the last part
  bit  hold_done = 1'b0;

  // Exact brute-force search; strict less-than keeps the lowest index on ties.
  function automatic nearest_t nearest_frame(input coord_t tx, input coord_t ty,
                                             input coord_t tz);
    nearest_t r;
    int       n;
    longint   dx, dy, dz, cost, best_cost;
    r = '0;
    best_cost = 0;
    n = (fc_shadow > MAX_FRAMES) ? MAX_FRAMES : int'(fc_shadow);  // count clamps
    for (int i = 0; i < n; i++) begin
      dx = longint'(frame_x[i]) - longint'(tx);
      dy = longint'(frame_y[i]) - longint'(ty);
      dz = longint'(frame_z[i]) - longint'(tz);
      cost = dx * dx + dy * dy + dz * dz;
      if (i == 0 || cost < best_cost) begin
        best_cost = cost;
        r.best = IDX_W'(i);
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  // Called on every accepted input word.
  task automatic apply_word(input stim_word_t w);
    if (w.op == OP_WRITE) begin
      if (w.idx < MAX_FRAMES) begin
        frame_x[w.idx] = w.x;
        frame_y[w.idx] = w.y;
        frame_z[w.idx] = w.z;
        frame_valid[w.idx] = 1'b1;
      end
      n_writes++;
    end else begin
      nearest_q.push_back(nearest_frame(w.x, w.y, w.z));
      n_queries++;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    err_count++;
    if (err_count <= 50) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. Valid is held while tready is low; random idle bursts are
  // inserted only between words, and some stretches run gap-free.
  // ---------------------------------------------------------------------------
  stim_word_t word_on_bus;
  int         src_gap = 0;
  int         src_regime = 0;
  bit         src_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_word(word_on_bus);
      if (src_regime == 0) begin
        src_regime = $urandom_range(50, 150);
        src_calm   = ($urandom_range(0, 2) == 0);
      end else begin
        src_regime--;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && !src_calm && $urandom_range(0, 3) == 0) begin
          src_gap = $urandom_range(0, 6);
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          s_axis_tdata  <= {6'b0, word_on_bus.z, word_on_bus.y, word_on_bus.x,
                            word_on_bus.idx};
          s_axis_tuser  <= word_on_bus.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and back-pressure. Once, after some results, tready drops
  // for a long stretch while the driver still has words queued, so the core
  // backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int snk_gap = 0;
  int snk_regime = 0;
  bit snk_calm = 1'b0;
  int hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    nearest_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (nearest_q.size() == 0) begin
          flag_mismatch("result word with no query waiting");
        end else begin
          want = nearest_q.pop_front();
          if (m_axis_tuser[0] !== want.found)
            flag_mismatch($sformatf("found: got %0b want %0b", m_axis_tuser[0],
                                    want.found));
          if (m_axis_tdata[IDX_W-1:0] !== want.best)
            flag_mismatch($sformatf("best_index: got %0d want %0d",
                                    m_axis_tdata[IDX_W-1:0], want.best));
        end
      end
      if (snk_regime == 0) begin
        snk_regime = $urandom_range(50, 150);
        snk_calm   = ($urandom_range(0, 2) == 0);
      end else begin
        snk_regime--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_results >= 20 && pending_words.size() > 4) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (snk_gap != 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && !snk_calm && $urandom_range(0, 3) == 0) begin
        snk_gap = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no word moving on either stream.
  int stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic op, input int idx, input coord_t x,
                           input coord_t y, input coord_t z);
    stim_word_t w;
    w.op  = op;
    w.idx = IDX_W'(idx);
    w.x   = x;
    w.y   = y;
    w.z   = z;
    pending_words.push_back(w);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return coord_t'($urandom_range(0, 512) - 256);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Write to idx: random position, or a copy of a written entry to force ties.
  task automatic push_frame(input int idx);
    int j;
    j = $urandom_range(0, MAX_FRAMES - 1);
    if (frame_valid[j] && $urandom_range(0, 4) == 0)
      push_word(OP_WRITE, idx, frame_x[j], frame_y[j], frame_z[j]);
    else
      push_word(OP_WRITE, idx, rand_coord(), rand_coord(), rand_coord());
  endtask

  // Query against the first n entries: on a frame, near one, or anywhere.
  task automatic push_query(input int n);
    int     j;
    coord_t dx, dy, dz;
    j  = (n > 0) ? $urandom_range(0, n - 1) : 0;
    dx = coord_t'($urandom_range(0, 8) - 4);
    dy = coord_t'($urandom_range(0, 8) - 4);
    dz = coord_t'($urandom_range(0, 8) - 4);
    case ((n > 0) ? $urandom_range(0, 3) : 0)
      0: push_word(OP_QUERY, $urandom_range(0, 1023), rand_coord(), rand_coord(),
                   rand_coord());
      1: push_word(OP_QUERY, $urandom_range(0, 1023), frame_x[j], frame_y[j],
                   frame_z[j]);
      default: push_word(OP_QUERY, $urandom_range(0, 1023), frame_x[j] + dx,
                         frame_y[j] + dy, frame_z[j] + dz);
    endcase
  endtask

  // Wait until the core has taken every word and returned every result.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || s_axis_tvalid || nearest_q.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic set_frame_count(input int v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= FC_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    fc_shadow = FC_W'(v);
    n_settings++;
    @(negedge clk_i);
  endtask

  function automatic int written_prefix();
    int p;
    p = 0;
    while (p < MAX_FRAMES && frame_valid[p]) p++;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int fc, p, len, rand_words, lim;
    rand_words = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty search straight out of reset (frame_count resets to 0).
    push_word(OP_QUERY, 0, 16'sh0000, 16'sh0000, 16'sh0000);
    push_word(OP_QUERY, 1023, 16'sh7fff, 16'sh8000, 16'sh7fff);
    // Corner frames; entry 4 duplicates entry 1 so a tie must go to index 1.
    push_word(OP_WRITE, 0, 16'sh8000, 16'sh8000, 16'sh8000);
    push_word(OP_WRITE, 1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_word(OP_WRITE, 2, 16'sh0000, 16'sh0000, 16'sh0000);
    push_word(OP_WRITE, 3, 16'sh7fff, 16'sh8000, 16'sh0000);
    push_word(OP_WRITE, 4, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_word(OP_WRITE, 1023, 16'shffff, 16'shffff, 16'shffff);
    settle();
    set_frame_count(5);
    push_word(OP_QUERY, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);     // tie 1 vs 4
    push_word(OP_QUERY, 0, 16'sh8000, 16'sh8000, 16'sh8000);
    push_word(OP_QUERY, 0, 16'sh0000, 16'sh0000, 16'sh0001);
    push_word(OP_QUERY, 0, 16'sh7fff, 16'sh8000, 16'sh0000);
    push_word(OP_QUERY, 1023, 16'sh8000, 16'sh7fff, 16'sh8000);  // widest distances
    push_word(OP_QUERY, 0, 16'sh0000, 16'sh8000, 16'sh0000);     // entry 3 just nearer than entry 2
    settle();
    set_frame_count(1);
    push_word(OP_QUERY, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    settle();
    set_frame_count(0);
    push_word(OP_QUERY, 0, 16'sh0100, 16'sh0100, 16'sh0100);

    // Random phases: small frame counts, mixed writes and queries. Writes
    // mostly extend the written prefix so later phases can search further.
    while (rand_words < RAND_WORDS) begin
      settle();
      p = written_prefix();
      lim = (p < 40) ? p : 40;
      case ($urandom_range(0, 9))
        0:       fc = 0;
        1:       fc = (p <= 200) ? p : lim;
        default: fc = (lim > 0) ? $urandom_range(1, lim) : 0;
      endcase
      set_frame_count(fc);
      len = $urandom_range(15, 40);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) < 6)
          push_query(fc);
        else if ($urandom_range(0, 4) == 0)
          push_frame($urandom_range(0, MAX_FRAMES - 1));
        else
          push_frame($urandom_range(0, (p + 3 < MAX_FRAMES) ? p + 3 : MAX_FRAMES - 1));
      end
      rand_words += len;
    end

    // Last part, no idling: extend the written prefix, then search all of it.
    settle();
    quiet = 1'b1;
    for (int i = 0; i < TAIL_FILL; i++)
      if (!frame_valid[i]) push_frame(i);
    settle();
    p = written_prefix();
    set_frame_count(p);
    repeat (8) push_query(p);
    settle();

    $display("run: %0d frame writes, %0d queries, %0d results, %0d frame_count settings",
             n_writes, n_queries, n_results, n_settings);
    $display("long output hold %s, %0d mismatches",
             hold_done ? "done" : "missed", err_count);
    if (err_count == 0 && nearest_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
